### design/dfr_pkg.sv
// ----------------------------------------------------------------------------
// Delimited frame receiver package
// Shared payload types, command codes and register indexes used by the
// front end, back end and top level of the frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes.
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_START   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_END     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    // Reset value of the timeout register.
    localparam logic [7:0] TIMEOUT_RESET = 8'd50;

    // Position of the length check byte, and the offset taken off the frame length it is compared with.
    localparam int CHECK_INDEX   = 5;
    localparam int LENGTH_OFFSET = 8;

    // One input transaction.
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    // One output transaction.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_index;
        logic       last;
    } t_out_item;

endpackage

### design/dfr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/dfr_fifo.sv
// ----------------------------------------------------------------------------
// Frame command queue
// Small FIFO that carries completed frame lengths from the front end to the
// back end.
// ----------------------------------------------------------------------------
module dfr_fifo #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr_ptr + 1'b1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(r_rd_ptr + 1'b1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

### design/dfr_front.sv
// ----------------------------------------------------------------------------
// Frame receiver front end
// Accepts bytes and ticks, tracks the open frame, writes the frame store and
// queues the length of each completed frame.
// ----------------------------------------------------------------------------
module dfr_front #(
    parameter int FRAME_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration writes.
    input  logic                                 i_cfg_we,
    input  logic [dfr_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [7:0]                           i_cfg_data,
    // Input channel.
    input  logic                                 i_in_valid,
    input  logic                                 i_hold,
    input  dfr_pkg::t_in_item                    i_in_data,
    // Frame store write port.
    output logic                                 o_we,
    output logic [$clog2(FRAME_DEPTH)-1:0]       o_waddr,
    output logic [7:0]                           o_wdata,
    // Completed frame lengths.
    output logic                                 o_push,
    output logic [$clog2(FRAME_DEPTH+1)-1:0]     o_push_len
);

    import dfr_pkg::*;

    localparam int LW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    logic [7:0]    r_start_byte;
    logic [7:0]    r_end_byte;
    logic [7:0]    r_timeout;
    logic          r_receiving;
    logic          n_receiving;
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic [7:0]    r_tick;
    logic [7:0]    n_tick;
    logic [7:0]    r_check_byte;

    logic          w_accept;
    logic [8:0]    w_tick_next;
    logic [LW-1:0] w_new_len;
    logic          w_complete;

    assign w_accept    = i_in_valid && !i_hold;
    assign w_tick_next = {1'b0, r_tick} + 9'd1;
    assign w_new_len   = LW'(r_len + 1'b1);
    assign w_complete  = (i_in_data.rx_byte == r_end_byte)
                      && (w_new_len >= LW'(LENGTH_OFFSET))
                      && (r_check_byte == 8'(w_new_len - LW'(LENGTH_OFFSET)));

    assign o_waddr    = r_len[AW-1:0];
    assign o_wdata    = i_in_data.rx_byte;
    assign o_push_len = w_new_len;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_end_byte   <= '0;
            r_timeout    <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START:   r_start_byte <= i_cfg_data;
                REG_END:     r_end_byte   <= i_cfg_data;
                REG_TIMEOUT: r_timeout    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Frame tracking: start, append, overflow, completion and timeout.
    always_comb begin
        n_receiving = r_receiving;
        n_len       = r_len;
        n_tick      = r_tick;
        o_we        = 1'b0;
        o_push      = 1'b0;
        if (w_accept) begin
            if (i_in_data.cmd == CMD_TICK) begin
                if (r_receiving) begin
                    if (w_tick_next > {1'b0, r_timeout}) begin
                        n_receiving = 1'b0;
                        n_len       = '0;
                        n_tick      = '0;
                    end else begin
                        n_tick = w_tick_next[7:0];
                    end
                end
            end else if (r_receiving || (i_in_data.rx_byte == r_start_byte)) begin
                if (r_len == LW'(FRAME_DEPTH)) begin
                    // Store is full: drop the frame.
                    n_receiving = 1'b0;
                    n_len       = '0;
                    n_tick      = '0;
                end else begin
                    o_we = 1'b1;
                    if (w_complete) begin
                        o_push      = 1'b1;
                        n_receiving = 1'b0;
                        n_len       = '0;
                        n_tick      = '0;
                    end else begin
                        n_receiving = 1'b1;
                        n_len       = w_new_len;
                        n_tick      = r_receiving ? r_tick : 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_len       <= '0;
            r_tick      <= '0;
        end else begin
            r_receiving <= n_receiving;
            r_len       <= n_len;
            r_tick      <= n_tick;
        end
    end

    // Copy of the length check byte, kept beside the store.
    always_ff @(posedge i_clk) begin
        if (o_we && (r_len == LW'(CHECK_INDEX))) begin
            r_check_byte <= i_in_data.rx_byte;
        end
    end

endmodule

### design/dfr_back.sv
// ----------------------------------------------------------------------------
// Frame receiver back end
// Takes a completed frame length from the queue, reads the frame store one
// byte per cycle while there is room downstream and presents the bytes through
// an output register and skid stage.
// ----------------------------------------------------------------------------
module dfr_back #(
    parameter int FRAME_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Queue of completed frame lengths.
    input  logic                                 i_empty,
    input  logic [$clog2(FRAME_DEPTH+1)-1:0]     i_len,
    output logic                                 o_pop,
    output logic                                 o_busy,
    // Frame store read port.
    output logic                                 o_re,
    output logic [$clog2(FRAME_DEPTH)-1:0]       o_raddr,
    input  logic [7:0]                           i_rdata,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output dfr_pkg::t_out_item                   o_out_data
);

    import dfr_pkg::*;

    localparam int LW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    logic          r_busy;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_rd_addr;
    logic          r_pend;
    logic [5:0]    r_pend_idx;
    logic          r_pend_last;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;
    logic          r_skid_valid;
    logic          n_skid_valid;
    t_out_item     r_skid;
    t_out_item     n_skid;

    logic          w_take;
    logic [1:0]    w_occupancy;
    logic          w_last;
    t_out_item     w_arrival;

    assign w_take      = r_out_valid && !i_out_stall;
    assign w_occupancy = 2'({1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, r_pend}
                            - {1'b0, w_take});
    assign w_last      = (LW'(r_rd_addr + 1'b1) == r_len);

    assign o_pop   = !r_busy && !i_empty;
    assign o_busy  = r_busy;
    assign o_re    = r_busy && (w_occupancy <= 2'd1);
    assign o_raddr = r_rd_addr[AW-1:0];

    assign w_arrival = '{frame_byte: i_rdata, byte_index: r_pend_idx, last: r_pend_last};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Read sequencer: one store read per cycle while there is room downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= o_re;
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (o_re && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_len     <= i_len;
            r_rd_addr <= '0;
        end else if (o_re) begin
            r_rd_addr <= LW'(r_rd_addr + 1'b1);
        end
        if (o_re) begin
            r_pend_idx  <= 6'(r_rd_addr);
            r_pend_last <= w_last;
        end
    end

    // Output register with a skid stage behind it.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = r_pend;
                n_skid       = w_arrival;
            end else begin
                n_out_valid = r_pend;
                n_out       = w_arrival;
            end
        end else if (r_pend) begin
            n_skid_valid = 1'b1;
            n_skid       = w_arrival;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

### design/delimited_frame_receiver.sv
// ----------------------------------------------------------------------------
// Delimited frame receiver
// Collects serial bytes into frames bounded by start and end delimiters,
// drops frames on overflow or timeout, and streams each completed frame out.
//
// Input channel: i_in_valid / o_in_stall with i_in_data (cmd, rx_byte). A
// transaction is either a received byte or a timer tick. Each one takes a
// single cycle while no completed frame is queued or still being read out.
// Output channel: o_out_valid / i_out_stall with o_out_data (frame_byte,
// byte_index, last). One transaction per frame byte, last set on the final
// byte.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// always ready, writes to unknown indexes are ignored.
// Readout: a completed frame's length passes the queue and the read sequencer;
// the store's registered read data then goes to the output register, one byte
// per cycle while the output is not stalled. The store reads set that pace.
// The input stalls from completion until the last store read.
// Reset: idle, no frame open, start and end bytes 0, timeout 50 ticks.
// A stall on the output pauses the store reads and keeps the input stalled.
// ----------------------------------------------------------------------------
module delimited_frame_receiver #(
    parameter int FRAME_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dfr_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dfr_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dfr_pkg::t_out_item            o_out_data
);

    import dfr_pkg::*;

    localparam int LW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic          w_push;
    logic [LW-1:0] w_push_len;
    logic          w_fifo_full;
    logic          w_fifo_empty;
    logic [LW-1:0] w_pop_len;
    logic          w_pop;
    logic          w_back_busy;

    assign o_cfg_ready = 1'b1;

    // Hold the input while a completed frame is queued or still being read out.
    assign o_in_stall = w_back_busy || !w_fifo_empty;

    dfr_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_hold      (o_in_stall),
        .i_in_data   (i_in_data),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_push      (w_push),
        .o_push_len  (w_push_len)
    );

    dfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dfr_fifo #(
        .WIDTH (LW),
        .DEPTH (2)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_len),
        .o_full      (w_fifo_full),
        .i_pop       (w_pop),
        .o_empty     (w_fifo_empty),
        .o_pop_data  (w_pop_len)
    );

    dfr_back #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_fifo_empty),
        .i_len       (w_pop_len),
        .o_pop       (w_pop),
        .o_busy      (w_back_busy),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A completed frame never finds the queue full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_push |-> !w_fifo_full)
        else $error("frame queue overflow");

    // The store is never written while a frame is being read out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_we |-> !w_back_busy)
        else $error("frame store written during readout");

    // Once a frame is queued, the back end takes it from the queue on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
                     w_push |=> (w_pop && !w_back_busy))
        else $error("queued frame not taken by the back end");

endmodule

### bench/tb_delimited_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delimited frame receiver testbench
// Sends received bytes and timer ticks through the input channel, writes the
// delimiter and timeout registers between phases, and checks every emitted
// frame byte against an in-bench model of framing, overflow and timeout.
// ----------------------------------------------------------------------------
module tb_delimited_frame_receiver;

    import dfr_pkg::*;

    localparam int FRAME_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int TICK_FLUSH_MAX = 60;

    // One row of the directed table; n_out is the listed frame byte count.
    typedef struct packed {
        logic       cmd;
        logic [7:0] val;
        logic       chk;
        logic [5:0] n_out;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;

    // Register shadows and frame tracking state.
    logic [7:0] cfg_start;
    logic [7:0] cfg_end;
    logic [7:0] cfg_timeout;
    logic [7:0] frame_copy [FRAME_DEPTH];
    int         rx_len;
    int         tick_cnt;
    bit         rx_open;

    t_out_item  frame_bytes_due [$];
    t_in_item   burst_q [$];

    int  errors;
    int  items_total;
    int  bytes_predicted;
    int  bytes_checked;
    int  frames_done;
    int  overflow_drops;
    int  timeout_drops;
    int  settings_used;
    int  stall_left;
    bit  gaps_en;
    bit  stall_en = 1'b0;

    // Directed rows run with start and end both at 0 and a timeout of 1.
    t_dir_row dir_rows [0:22] = '{
        '{CMD_TICK, 8'hFF, 1'b1, 6'd0},   // tick while idle
        '{CMD_BYTE, 8'hFF, 1'b1, 6'd0},   // not a start byte, ignored
        '{CMD_BYTE, 8'h00, 1'b0, 6'd0},   // opens a frame
        '{CMD_BYTE, 8'h11, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h22, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h33, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h44, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h00, 1'b0, 6'd0},   // end byte in a short frame
        '{CMD_BYTE, 8'h66, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h00, 1'b1, 6'd8},   // shortest complete frame
        '{CMD_BYTE, 8'h00, 1'b0, 6'd0},   // start equals end
        '{CMD_BYTE, 8'h80, 1'b0, 6'd0},
        '{CMD_TICK, 8'h00, 1'b1, 6'd0},   // first tick times the frame out
        '{CMD_BYTE, 8'h80, 1'b1, 6'd0},
        '{CMD_BYTE, 8'h00, 1'b0, 6'd0},
        '{CMD_BYTE, 8'hFF, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h01, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h02, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h03, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h01, 1'b0, 6'd0},   // length check byte asks for 9
        '{CMD_BYTE, 8'h7F, 1'b0, 6'd0},
        '{CMD_BYTE, 8'h00, 1'b1, 6'd0},   // end byte with a failed check
        '{CMD_BYTE, 8'h00, 1'b1, 6'd9}
    };

    delimited_frame_receiver #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short waits, now and then a long one.
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < 30) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        errors++;
    endtask

    // Frame tracking: applies one accepted transaction and queues the frame
    // bytes it releases. Returns how many were queued.
    function automatic int absorb_item(input t_in_item it);
        t_out_item ob;
        int        n;
        items_total++;
        if (it.cmd == CMD_TICK) begin
            if (rx_open) begin
                if (tick_cnt + 1 > cfg_timeout) begin
                    rx_open = 1'b0;
                    timeout_drops++;
                end else begin
                    tick_cnt++;
                end
            end
            return 0;
        end
        if (!rx_open) begin
            if (it.rx_byte != cfg_start) return 0;
            rx_len   = 0;
            tick_cnt = 1;
            rx_open  = 1'b1;
        end
        // The store is full: the frame is dropped and the byte discarded.
        if (rx_len >= FRAME_DEPTH) begin
            rx_open = 1'b0;
            overflow_drops++;
            return 0;
        end
        frame_copy[rx_len] = it.rx_byte;
        rx_len++;
        if (it.rx_byte != cfg_end || rx_len < LENGTH_OFFSET ||
            frame_copy[CHECK_INDEX] != rx_len - LENGTH_OFFSET) begin
            return 0;
        end
        n = rx_len;
        for (int k = 0; k < n; k++) begin
            ob.frame_byte = frame_copy[k];
            ob.byte_index = 6'(k);
            ob.last       = (k == n - 1);
            frame_bytes_due.push_back(ob);
        end
        rx_open = 1'b0;
        bytes_predicted += n;
        frames_done++;
        return n;
    endfunction

    // Sends one transaction after a random gap and tracks it once accepted.
    task automatic push_item(input t_in_item it, output int n);
        int gap;
        gap = gaps_en ? pick_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        n = absorb_item(it);
    endtask

    // Holds the input off until every frame byte has come out, plus slack.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [7:0] s, input logic [7:0] e,
                               input logic [7:0] t);
        logic [7:0]           vals [3];
        logic [REG_IDX_W-1:0] idxs [3];
        vals = '{s, e, t};
        idxs = '{REG_START, REG_END, REG_TIMEOUT};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data  <= vals[k];
            forever begin
                @(negedge i_clk);
                if (o_cfg_ready) break;
            end
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cfg_start   = s;
        cfg_end     = e;
        cfg_timeout = t;
        settings_used++;
    endtask

    function automatic void queue_byte(input logic [7:0] v);
        t_in_item it;
        it.cmd     = CMD_BYTE;
        it.rx_byte = v;
        burst_q.push_back(it);
    endfunction

    function automatic void queue_tick();
        t_in_item it;
        it.cmd     = CMD_TICK;
        it.rx_byte = 8'($urandom_range(0, 255));
        burst_q.push_back(it);
    endfunction

    // A random byte that can never close the frame.
    function automatic logic [7:0] filler();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == cfg_end) v[0] = ~v[0];
        return v;
    endfunction

    // Ends a frame left open by the previous sequence, by ticks when the
    // timeout is short and by overflowing the store otherwise.
    function automatic void close_open_frame();
        if (!rx_open) return;
        if (cfg_timeout <= TICK_FLUSH_MAX) begin
            repeat (cfg_timeout - tick_cnt + 1) queue_tick();
        end else begin
            repeat (FRAME_DEPTH - rx_len + 1) queue_byte(filler());
        end
    endfunction

    // A frame that completes on its last byte, with a few ticks inside.
    function automatic void queue_good_frame();
        logic [7:0] body [FRAME_DEPTH];
        int         len;
        int         allow;
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(20, FRAME_DEPTH)
                                          : $urandom_range(8, 14);
        allow = cfg_timeout - 1;
        for (int j = 0; j < len; j++) body[j] = 8'($urandom_range(0, 255));
        body[0]           = cfg_start;
        body[CHECK_INDEX] = 8'(len - LENGTH_OFFSET);
        body[len - 1]     = cfg_end;
        // Sometimes put an end byte early, where the frame is still short.
        if ($urandom_range(0, 2) == 0) begin
            body[$urandom_range(1, CHECK_INDEX - 1)] = cfg_end;
        end
        for (int j = 0; j < len; j++) begin
            if (j > 0 && allow > 0 && $urandom_range(0, 5) == 0) begin
                queue_tick();
                allow--;
            end
            queue_byte(body[j]);
        end
    endfunction

    // Builds one random sequence of transactions into the burst queue.
    function automatic void queue_sequence();
        int  kind;
        logic [7:0] v;
        close_open_frame();
        kind = $urandom_range(0, 9);
        if (kind == 7 && cfg_timeout > TICK_FLUSH_MAX) kind = 6;
        case (kind)
            6: begin
                // Frame that runs past the end of the store.
                queue_byte(cfg_start);
                repeat (FRAME_DEPTH) queue_byte(filler());
            end
            7: begin
                // Frame abandoned until the timeout expires.
                queue_byte(cfg_start);
                repeat ($urandom_range(1, 5)) queue_byte(filler());
                repeat (cfg_timeout) queue_tick();
            end
            8: begin
                // Idle noise that opens nothing.
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        queue_tick();
                    end else begin
                        v = 8'($urandom_range(0, 255));
                        if (v == cfg_start) v[0] = ~v[0];
                        queue_byte(v);
                    end
                end
            end
            9: begin
                // Frame cut short and left open for the next sequence.
                queue_byte(cfg_start);
                repeat ($urandom_range(1, 10)) queue_byte(filler());
            end
            default: begin
                queue_good_frame();
            end
        endcase
    endfunction

    task automatic send_burst();
        int n;
        while (burst_q.size() != 0) push_item(burst_q.pop_front(), n);
    endtask

    // One register setting followed by random sequences.
    task automatic run_phase(input logic [7:0] s, input logic [7:0] e,
                             input logic [7:0] t, input bit closing);
        int first_item;
        bit quiet;
        settle();
        load_config(s, e, t);
        first_item = items_total;
        while (items_total - first_item < 30 ||
               (closing && bytes_predicted < 48 && items_total - first_item < 400)) begin
            quiet    = ($urandom_range(0, 4) == 0);
            gaps_en  = !quiet;
            stall_en <= !quiet;
            queue_sequence();
            send_burst();
            if ($urandom_range(0, 7) == 0) settle();
        end
    endtask

    // Output stall: each open cycle may be followed by a stall of random length.
    always @(posedge i_clk) begin
        if (!stall_en) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_len();
        end
    end

    // Output check: a transaction seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected frame byte %02h index %0d",
                                          o_out_data.frame_byte, o_out_data.byte_index));
            end else begin
                want = frame_bytes_due.pop_front();
                if (o_out_data.frame_byte !== want.frame_byte) begin
                    report_mismatch($sformatf("frame_byte %02h, want %02h",
                                              o_out_data.frame_byte, want.frame_byte));
                end
                if (o_out_data.byte_index !== want.byte_index) begin
                    report_mismatch($sformatf("byte_index %0d, want %0d",
                                              o_out_data.byte_index, want.byte_index));
                end
                if (o_out_data.last !== want.last) begin
                    report_mismatch($sformatf("last %b, want %b at index %0d",
                                              o_out_data.last, want.last, want.byte_index));
                end
                bytes_checked++;
            end
        end
    end

    // Main sequence.
    initial begin
        t_in_item   it;
        int         n;
        logic [7:0] rs;
        logic [7:0] re;
        rx_open     = 1'b0;
        rx_len      = 0;
        tick_cnt    = 0;
        cfg_start   = 8'h00;
        cfg_end     = 8'h00;
        cfg_timeout = TIMEOUT_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset delimiters and a timeout of 1.
        load_config(8'h00, 8'h00, 8'd1);
        gaps_en  = 1'b1;
        stall_en <= 1'b1;
        foreach (dir_rows[r]) begin
            it.cmd     = dir_rows[r].cmd;
            it.rx_byte = dir_rows[r].val;
            push_item(it, n);
            if (dir_rows[r].chk && n != dir_rows[r].n_out) begin
                report_mismatch($sformatf("directed row %0d releases %0d bytes, listed %0d",
                                          r, n, dir_rows[r].n_out));
            end
        end

        // Random phases across the register extremes.
        run_phase(8'hA5, 8'h5A, 8'd254, 1'b0);
        run_phase(8'hFF, 8'hFF, 8'd20, 1'b0);
        run_phase(8'h00, 8'hFF, 8'd1, 1'b0);
        rs = 8'($urandom_range(0, 255));
        re = ($urandom_range(0, 3) == 0) ? rs : 8'($urandom_range(0, 255));
        run_phase(rs, re, 8'($urandom_range(1, 254)), 1'b1);
        settle();

        $display("Covered %0d input transactions under %0d register settings:",
                 items_total, settings_used);
        $display("%0d frames, %0d bytes checked; dropped on a full store: %0d, on timeout: %0d.",
                 frames_done, bytes_checked, overflow_drops, timeout_drops);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("Timeout: %0d frame bytes still awaited.", frame_bytes_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
